// ===== src/ttsp_pkg.sv =====
`default_nettype none

package ttsp_pkg;

	localparam int INDEX_BITS  = 10;
	localparam int TABLE_DEPTH = 1 << INDEX_BITS;

	localparam int KEY_W    = 64;
	localparam int SCORE_W  = 16;
	localparam int DEPTH_W  = 15;
	localparam int BOUND_W  = 2;
	localparam int SQUARE_W = 7;
	localparam int AGE_W    = 16;

	// s_tdata layout, lowest bit first
	localparam int IN_KEY_LSB    = 0;
	localparam int IN_SCORE_LSB  = IN_KEY_LSB + KEY_W;
	localparam int IN_DEPTH_LSB  = IN_SCORE_LSB + SCORE_W;
	localparam int IN_BOUND_LSB  = IN_DEPTH_LSB + DEPTH_W;
	localparam int IN_SQUARE_LSB = IN_BOUND_LSB + BOUND_W;
	localparam int IN_BITS       = IN_SQUARE_LSB + SQUARE_W;
	localparam int IN_DATA_W     = ((IN_BITS + 7) / 8) * 8;

	// m_tdata layout: written, hit, score, depth, bound, square, age
	localparam int OUT_BITS   = 2 + SCORE_W + DEPTH_W + BOUND_W + SQUARE_W + AGE_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int OUT_PAD_W  = OUT_DATA_W - OUT_BITS;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} ttsp_state_t;

	typedef enum logic {
		MODE_STORE = 1'b0,
		MODE_LOAD  = 1'b1
	} ttsp_mode_t;

	typedef struct packed {
		logic [KEY_W-1:0]          key;
		logic signed [SCORE_W-1:0] score;
		logic [DEPTH_W-1:0]        depth;
		logic [BOUND_W-1:0]        bound;
		logic [SQUARE_W-1:0]       square;
		logic [AGE_W-1:0]          age;
	} ttsp_entry_t;

	typedef struct packed {
		ttsp_mode_t                mode;
		logic [KEY_W-1:0]          key;
		logic signed [SCORE_W-1:0] score;
		logic [DEPTH_W-1:0]        depth;
		logic [BOUND_W-1:0]        bound;
		logic [SQUARE_W-1:0]       square;
	} ttsp_req_t;

	typedef struct packed {
		logic                      written;
		logic                      hit;
		logic signed [SCORE_W-1:0] score;
		logic [DEPTH_W-1:0]        depth;
		logic [BOUND_W-1:0]        bound;
		logic [SQUARE_W-1:0]       square;
		logic [AGE_W-1:0]          age;
	} ttsp_result_t;

	typedef struct packed {
		logic clr_step;
		logic capture;
		logic commit;
	} ttsp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic out_free;
	} ttsp_status_t;

endpackage

`default_nettype wire

// ===== src/ttsp_ctrl.sv =====
`default_nettype none

module ttsp_ctrl
	import ttsp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire ttsp_status_t status,
	output ttsp_cmd_t        cmd
);

	ttsp_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
			end
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			ST_LOOKUP: begin
				cmd.commit = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/ttsp_dp.sv =====
`default_nettype none

module ttsp_dp
	import ttsp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [AGE_W-1:0]      cfg_wr_data,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic                  s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,
	input  wire ttsp_cmd_t             cmd,
	output ttsp_status_t               status
);

	ttsp_entry_t               mem [TABLE_DEPTH];
	ttsp_entry_t               rd_data_q;
	ttsp_entry_t               wr_data;
	logic                      wr_en;
	logic [INDEX_BITS-1:0]     wr_addr;
	logic [INDEX_BITS-1:0]     rd_addr;

	logic [INDEX_BITS-1:0]     clr_cnt_q;
	logic [AGE_W-1:0]          age_q;
	ttsp_req_t                 req_q;
	ttsp_req_t                 req_in;
	ttsp_result_t              out_q;
	ttsp_result_t              res;
	logic                      out_valid_q;
	logic                      key_match;
	logic                      replace;

	// unpack the incoming beat
	always_comb begin
		req_in.mode   = ttsp_mode_t'(s_tuser);
		req_in.key    = s_tdata[IN_KEY_LSB +: KEY_W];
		req_in.score  = s_tdata[IN_SCORE_LSB +: SCORE_W];
		req_in.depth  = s_tdata[IN_DEPTH_LSB +: DEPTH_W];
		req_in.bound  = s_tdata[IN_BOUND_LSB +: BOUND_W];
		req_in.square = s_tdata[IN_SQUARE_LSB +: SQUARE_W];
	end

	assign rd_addr = req_in.key[INDEX_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= '0;
		end else if (cfg_wr_en) begin
			age_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_step) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	assign status.clr_last = (clr_cnt_q == {INDEX_BITS{1'b1}});

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_in;
		end
	end

	// replacement decision on the entry read at capture
	assign key_match = (rd_data_q.key == req_q.key);
	assign replace   = !key_match || (req_q.depth >= rd_data_q.depth) ||
	                   (rd_data_q.age != age_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = req_q.key[INDEX_BITS-1:0];
		wr_data = '0;
		if (cmd.clr_step) begin
			wr_en   = 1'b1;
			wr_addr = clr_cnt_q;
		end else if (cmd.commit && req_q.mode == MODE_STORE && replace) begin
			wr_en          = 1'b1;
			wr_data.key    = req_q.key;
			wr_data.score  = req_q.score;
			wr_data.depth  = req_q.depth;
			wr_data.bound  = req_q.bound;
			wr_data.square = req_q.square;
			wr_data.age    = age_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.capture) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_comb begin
		res = '0;
		if (req_q.mode == MODE_STORE) begin
			res.written = replace;
		end else if (key_match) begin
			res.hit    = 1'b1;
			res.score  = rd_data_q.score;
			res.depth  = rd_data_q.depth;
			res.bound  = rd_data_q.bound;
			res.square = rd_data_q.square;
			res.age    = rd_data_q.age;
		end
	end

	// output register, frees the lookup stage from the consumer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q <= res;
		end
	end

	assign status.out_free = !out_valid_q || m_tready;
	assign m_tvalid        = out_valid_q;
	assign m_tdata         = {{OUT_PAD_W{1'b0}}, out_q.age, out_q.square, out_q.bound,
	                          out_q.depth, out_q.score, out_q.hit, out_q.written};

endmodule

`default_nettype wire

// ===== src/transposition_table_store_probe_top.sv =====
`default_nettype none

// direct-mapped transposition table of 1024 entries, indexed by the low 10 bits
// of the 64-bit position key. a beat with s_tuser = 0 stores: the entry is
// replaced when its key differs, when the new depth is at least the stored
// depth, or when its age differs from current_age, and the new entry takes
// current_age as its stamp; the result reports written. a beat with s_tuser = 1
// probes: hit is set when the stored key equals the request, and the stored
// fields come back, else all fields read 0. every input beat gives exactly one
// result beat. after reset the table is swept to zero one entry a cycle, and
// s_tready stays low until the sweep is done; a fresh entry matches key 0.
// each request has an accept step, which takes the beat and reads the table
// entry into its registered read port, and a lookup step, which decides,
// writes back and loads the output register. s_tready is high only in the
// idle state, so a request is taken only once the last has left lookup; while
// a result waits in the output register the next request is still accepted
// and its lookup holds until that result is taken. cfg_wr_en updates
// current_age on any edge and is meant to be used while no request is in flight.

module transposition_table_store_probe_top
	import ttsp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	// current_age register
	input  wire logic                  cfg_wr_en,
	input  wire logic [AGE_W-1:0]      cfg_wr_data,

	// request side
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// position_key[63:0], score[79:64], search_depth[94:80], bound_kind[96:95],
	// move_square[103:97]
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// mode: 0 store, 1 load
	input  wire logic                  s_tuser,

	// result side
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// written[0], hit[1], found_score[17:2], found_depth[32:18],
	// found_bound[34:33], found_square[41:35], found_age[57:42], zero[63:58]
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	ttsp_cmd_t    cmd;
	ttsp_status_t status;

	// sequencer: clear sweep, accept, lookup/commit
	ttsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// table memory, age register, replacement compare and output register
	ttsp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cmd         (cmd),
		.status      (status)
	);

endmodule

`default_nettype wire

// ===== src/ttsp_checker.sv =====
`default_nettype none

module ttsp_checker
	import ttsp_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tvalid,
	input wire logic                  s_tready,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// one request in flight: ready drops right after an accepted beat
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted during lookup");

	// store and probe flags never both set
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("written and hit both set");

	// without a hit every found field and the padding read zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[1] |-> m_tdata[OUT_DATA_W-1:2] == '0)
		else $error("found fields not zero without hit");

endmodule

bind transposition_table_store_probe_top ttsp_checker u_ttsp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/tb_transposition_table_store_probe_top.sv =====
`timescale 1ns / 1ps

module tb_transposition_table_store_probe_top;
	import ttsp_pkg::*;

	localparam int POOL_SIZE = 48;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [AGE_W-1:0]     cfg_wr_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	// position_key, score, search_depth, bound_kind, move_square, lowest bit first
	logic [IN_DATA_W-1:0] s_tdata = '0;
	// mode: 0 store, 1 load
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// written, hit, found_score, found_depth, found_bound, found_square, found_age, pad
	logic [OUT_DATA_W-1:0] m_tdata;

	transposition_table_store_probe_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	// shadow copy of the table and the age register
	ttsp_entry_t      shadow_table [TABLE_DEPTH];
	logic [AGE_W-1:0] shadow_age;

	ttsp_req_t    request_queue [$];   // requests not yet offered to the block
	ttsp_result_t due_results [$];     // predicted results, oldest first
	ttsp_req_t    offered_req;         // request on the bus right now
	logic         s_fire = 1'b0;       // request beat taken at the last rising edge
	logic         calm = 1'b0;         // no idling on either side
	int           tx_gap = 0;
	int           rx_gap = 0;
	int           mismatch_count = 0;
	int           results_seen = 0;
	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	initial begin
		forever #5 clk = ~clk;
	end

	// safety net against a hung handshake
	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	// predicted outcome of one request, updating the shadow table as the block should
	function automatic ttsp_result_t probe_table(ttsp_req_t rq);
		ttsp_result_t          r;
		logic [INDEX_BITS-1:0] slot;
		slot = rq.key[INDEX_BITS-1:0];
		r = '0;
		if (rq.mode == MODE_STORE) begin
			// replace on a foreign key, an equal or deeper search, or a stale generation
			if (shadow_table[slot].key != rq.key || rq.depth >= shadow_table[slot].depth ||
			    shadow_table[slot].age != shadow_age) begin
				shadow_table[slot].key    = rq.key;
				shadow_table[slot].score  = rq.score;
				shadow_table[slot].depth  = rq.depth;
				shadow_table[slot].bound  = rq.bound;
				shadow_table[slot].square = rq.square;
				shadow_table[slot].age    = shadow_age;
				r.written = 1'b1;
			end
		end else if (shadow_table[slot].key == rq.key) begin
			r.hit    = 1'b1;
			r.score  = shadow_table[slot].score;
			r.depth  = shadow_table[slot].depth;
			r.bound  = shadow_table[slot].bound;
			r.square = shadow_table[slot].square;
			r.age    = shadow_table[slot].age;
		end
		return r;
	endfunction

	task automatic log_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s", msg);
	endtask

	// request driver: presents the next queued request, with random gaps
	always @(negedge clk) begin : drive_requests
		ttsp_req_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_fire) begin
			if (tx_gap != 0) begin
				tx_gap   <= tx_gap - 1;
				s_tvalid <= 1'b0;
			end else if (!calm && request_queue.size() != 0 && $urandom_range(0, 6) == 0) begin
				// start an idle burst
				tx_gap   <= $urandom_range(0, 7);
				s_tvalid <= 1'b0;
			end else if (request_queue.size() != 0) begin
				nxt = request_queue.pop_front();
				offered_req <= nxt;
				s_tvalid    <= 1'b1;
				s_tuser     <= nxt.mode;
				s_tdata     <= {nxt.square, nxt.bound, nxt.depth, nxt.score, nxt.key};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result side back-pressure in bursts
	always @(negedge clk) begin : drive_ready
		if (calm) begin
			m_tready <= 1'b1;
		end else if (rx_gap != 0) begin
			rx_gap   <= rx_gap - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			rx_gap   <= $urandom_range(0, 7);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// monitor: check result beats first, then predict for the request beat
	always @(posedge clk) begin : watch_beats
		ttsp_result_t got;
		ttsp_result_t want;
		s_fire <= arst_n && s_tvalid && s_tready;
		if (arst_n && m_tvalid && m_tready) begin
			got.written = m_tdata[0];
			got.hit     = m_tdata[1];
			got.score   = m_tdata[17:2];
			got.depth   = m_tdata[32:18];
			got.bound   = m_tdata[34:33];
			got.square  = m_tdata[41:35];
			got.age     = m_tdata[57:42];
			if (due_results.size() == 0) begin
				log_mismatch($sformatf("result %0d: none expected, got %h", results_seen, m_tdata));
			end else begin
				want = due_results.pop_front();
				if (got !== want)
					log_mismatch($sformatf({"result %0d: expected wr=%0d hit=%0d score=%0d ",
						"depth=%0d bound=%0d sq=%0d age=%0d, got wr=%0d hit=%0d score=%0d ",
						"depth=%0d bound=%0d sq=%0d age=%0d"}, results_seen,
						want.written, want.hit, want.score, want.depth, want.bound,
						want.square, want.age, got.written, got.hit, got.score, got.depth,
						got.bound, got.square, got.age));
			end
			results_seen++;
		end
		if (arst_n && s_tvalid && s_tready)
			due_results = {due_results, probe_table(offered_req)};
	end

	task automatic queue_req(ttsp_mode_t mode, logic [KEY_W-1:0] key, logic [SCORE_W-1:0] score,
	                         logic [DEPTH_W-1:0] depth, logic [BOUND_W-1:0] bound,
	                         logic [SQUARE_W-1:0] square);
		ttsp_req_t rq;
		rq.mode   = mode;
		rq.key    = key;
		rq.score  = score;
		rq.depth  = depth;
		rq.bound  = bound;
		rq.square = square;
		request_queue = {request_queue, rq};
	endtask

	// mostly keys from a colliding pool so stores and loads meet, some noise keys
	task automatic queue_random(int count);
		ttsp_req_t rq;
		for (int i = 0; i < count; i++) begin
			rq.mode = ttsp_mode_t'($urandom_range(0, 1));
			case ($urandom_range(0, 9))
				0: rq.key = {$urandom, $urandom};
				1: rq.key = '0;
				default: rq.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			endcase
			rq.score = SCORE_W'($urandom);
			// small depths make the keep-or-replace decision go both ways
			if ($urandom_range(0, 3) == 0)
				rq.depth = DEPTH_W'($urandom);
			else
				rq.depth = DEPTH_W'($urandom_range(0, 15));
			rq.bound = BOUND_W'($urandom_range(0, 3));
			if ($urandom_range(0, 4) == 0)
				rq.square = SQUARE_W'($urandom);
			else
				rq.square = SQUARE_W'($urandom_range(0, 64));
			request_queue = {request_queue, rq};
		end
	endtask

	// wait for the block to drain before touching the age register
	task automatic wait_drained();
		while (request_queue.size() != 0 || s_tvalid || due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_age(logic [AGE_W-1:0] value);
		@(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = value;
		shadow_age  = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	initial begin : run_phases
		logic [AGE_W-1:0]      phase_ages [6];
		logic [INDEX_BITS-1:0] pool_slots [12];
		for (int i = 0; i < TABLE_DEPTH; i++)
			shadow_table[i] = '0;
		shadow_age = '0;

		// a dozen shared slots, the two end slots among them
		pool_slots[0] = '0;
		pool_slots[1] = '1;
		for (int i = 2; i < 12; i++)
			pool_slots[i] = INDEX_BITS'($urandom);
		for (int i = 0; i < POOL_SIZE; i++) begin
			key_pool[i] = {$urandom, $urandom};
			key_pool[i][INDEX_BITS-1:0] = pool_slots[i % 12];
		end
		key_pool[0] = '0;
		key_pool[1] = '1;

		phase_ages[0] = 16'h0001;
		phase_ages[1] = 16'h0000;
		phase_ages[2] = AGE_W'($urandom);
		phase_ages[3] = 16'h8000;
		phase_ages[4] = AGE_W'($urandom);
		phase_ages[5] = 16'hFFFF;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part at generation 0
		write_age(16'h0000);
		// fresh table holds key 0 everywhere
		queue_req(MODE_LOAD, 64'h0, 16'h0, 15'h0, 2'd0, 7'd0);
		queue_req(MODE_LOAD, 64'h400, 16'h0, 15'h0, 2'd0, 7'd0);
		queue_req(MODE_LOAD, '1, 16'h0, 15'h0, 2'd0, 7'd0);
		// field extremes, out-of-range bound and square kept as raw bits
		queue_req(MODE_STORE, '1, 16'h8000, 15'h7FFF, 2'd3, 7'h7F);
		queue_req(MODE_LOAD, '1, 16'h0, 15'h0, 2'd0, 7'd0);
		// shallower store with same key and age is dropped
		queue_req(MODE_STORE, '1, 16'h7FFF, 15'h7FFE, 2'd0, 7'd0);
		queue_req(MODE_LOAD, '1, 16'h0, 15'h0, 2'd0, 7'd0);
		// equal depth replaces
		queue_req(MODE_STORE, '1, 16'h1234, 15'h7FFF, 2'd2, 7'd64);
		// foreign key in the same slot replaces even at depth 0
		queue_req(MODE_STORE, 64'h3FF, 16'hFFFF, 15'h0, 2'd1, 7'd63);
		queue_req(MODE_LOAD, '1, 16'h0, 15'h0, 2'd0, 7'd0);
		queue_req(MODE_LOAD, 64'h3FF, 16'h0, 15'h0, 2'd0, 7'd0);
		queue_req(MODE_STORE, 64'h0, 16'h0001, 15'h0, 2'd2, 7'd1);
		queue_req(MODE_STORE, 64'h8000_0000_0000_0001, 16'h0055, 15'd5, 2'd0, 7'd10);
		queue_req(MODE_STORE, 64'h8000_0000_0000_0001, 16'h00AA, 15'd4, 2'd1, 7'd11);
		queue_req(MODE_LOAD, 64'h8000_0000_0000_0001, 16'h0, 15'h0, 2'd0, 7'd0);
		wait_drained();

		// new generation: stale entries give way to shallower stores
		write_age(16'hFFFF);
		queue_req(MODE_STORE, 64'h8000_0000_0000_0001, 16'hFF00, 15'd1, 2'd2, 7'd20);
		queue_req(MODE_STORE, 64'h8000_0000_0000_0001, 16'h00FF, 15'd0, 2'd0, 7'd21);
		queue_req(MODE_LOAD, 64'h8000_0000_0000_0001, 16'h0, 15'h0, 2'd0, 7'd0);
		queue_req(MODE_LOAD, 64'h3FF, 16'h0, 15'h0, 2'd0, 7'd0);
		queue_req(MODE_STORE, 64'h3FF, 16'h4000, 15'h0, 2'd3, 7'd65);
		queue_req(MODE_LOAD, 64'h3FF, 16'h0, 15'h0, 2'd0, 7'd0);
		queue_req(MODE_LOAD, 64'h0, 16'h0, 15'h0, 2'd0, 7'd0);
		queue_req(MODE_LOAD, 64'h400, 16'h0, 15'h0, 2'd0, 7'd0);
		wait_drained();

		// random phases, each under its own generation; the last one runs flat out
		for (int p = 0; p < 6; p++) begin
			write_age(phase_ages[p]);
			if (p == 5)
				calm = 1'b1;
			queue_random(280);
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (due_results.size() != 0)
			log_mismatch($sformatf("%0d results never arrived", due_results.size()));
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
